// File: src/assert_macros.svh
// Assertion macros used by the checker file of the arming interlock.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is low.
`define AMX_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication that must hold whenever the qualifier is high.
`define AMX_ASSERT_IMP(lbl, clk, rst_n, qual, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (qual) |-> (cons)) else $error(msg);

`endif

// File: src/amx_pkg.sv
// Shared types and constants of the arming interlock and omni drive mixer.
// No dependencies; used by every module of the block by scoped names.
`timescale 1ns / 1ps

package amx_pkg;

  localparam int CH_W        = 7;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int WQ_W        = 25;
  localparam int NUM_W       = 29;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_DRIVE  = 2'd1,
    MODE_WEAPON = 2'd2,
    MODE_FULL   = 2'd3
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_THR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_LO  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_HI  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_MAX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE   = 3'd4;

  localparam logic [CH_W-1:0] RST_SWITCH_THR = 7'd50;
  localparam logic [CH_W-1:0] RST_CENTRE_LO  = 7'd45;
  localparam logic [CH_W-1:0] RST_CENTRE_HI  = 7'd55;
  localparam logic [CH_W-1:0] RST_THR_MAX    = 7'd2;
  localparam logic [CH_W-1:0] RST_DEADZONE   = 7'd5;

  localparam logic [CH_W-1:0] CH_CENTRE  = 7'd50;
  localparam logic [CH_W-1:0] LEVEL_MAX  = 7'd100;
  localparam logic [CH_W-1:0] WHEEL_STOP = 7'd50;

  // sqrt(3)/2 in Q16.
  localparam logic signed [17:0] SQRT3_HALF_Q16 = 18'sd56756;
  // Half of 7 * 65536, for round to nearest.
  localparam logic signed [NUM_W-1:0] ROUND_HALF = 29'sd229376;
  // Quotient by 65536 at or above which the level saturates at 100.
  localparam logic [12:0] SAT_U = 13'd707;
  // floor(u / 7) = (u * 9363) >> 16 for u below 707.
  localparam logic [13:0] DIV7_RECIP = 14'd9363;

  typedef struct packed {
    logic [CH_W-1:0] sw;
    logic [CH_W-1:0] thr;
    logic [CH_W-1:0] el;
    logic [CH_W-1:0] ru;
    logic [CH_W-1:0] ai;
    logic            lost;
  } chan_t;

  typedef struct packed {
    logic [CH_W-1:0] switch_thr;
    logic [CH_W-1:0] centre_lo;
    logic [CH_W-1:0] centre_hi;
    logic [CH_W-1:0] thr_max;
    logic [CH_W-1:0] deadzone;
  } cfg_t;

endpackage

// File: src/amx_arm.sv
// Arming mode update: failsafe demotion, then the arm and disarm rules.
// Depends on amx_pkg.
`timescale 1ns / 1ps

module amx_arm (
  input  amx_pkg::mode_t mode_i,
  input  amx_pkg::chan_t weapon_i,
  input  amx_pkg::chan_t drive_i,
  input  amx_pkg::cfg_t  cfg_i,
  output amx_pkg::mode_t mode_o
);

  logic           w_on;
  logic           d_on;
  logic           w_arm;
  logic           d_arm;
  amx_pkg::mode_t m_fs;

  function automatic logic centred(input logic [amx_pkg::CH_W-1:0] v,
                                   input amx_pkg::cfg_t c);
    centred = (v >= c.centre_lo) && (v <= c.centre_hi);
  endfunction

  function automatic logic may_arm(input logic on, input amx_pkg::chan_t ch,
                                   input amx_pkg::cfg_t c);
    may_arm = on && !ch.lost && (ch.thr <= c.thr_max) && centred(ch.el, c) &&
              centred(ch.ru, c) && centred(ch.ai, c);
  endfunction

  always_comb begin
    w_on  = weapon_i.sw > cfg_i.switch_thr;
    d_on  = drive_i.sw > cfg_i.switch_thr;
    w_arm = may_arm(w_on, weapon_i, cfg_i);
    d_arm = may_arm(d_on, drive_i, cfg_i);

    m_fs = mode_i;
    unique case (mode_i)
      amx_pkg::MODE_FULL: begin
        if (drive_i.lost && weapon_i.lost) m_fs = amx_pkg::MODE_OFF;
        else if (drive_i.lost)             m_fs = amx_pkg::MODE_WEAPON;
        else if (weapon_i.lost)            m_fs = amx_pkg::MODE_DRIVE;
      end
      amx_pkg::MODE_DRIVE: begin
        if (drive_i.lost) m_fs = amx_pkg::MODE_OFF;
      end
      amx_pkg::MODE_WEAPON: begin
        if (weapon_i.lost) m_fs = amx_pkg::MODE_OFF;
      end
      amx_pkg::MODE_OFF: begin
        m_fs = amx_pkg::MODE_OFF;
      end
    endcase

    mode_o = m_fs;
    unique case (m_fs)
      amx_pkg::MODE_FULL: begin
        if (!d_on && !w_on)     mode_o = amx_pkg::MODE_OFF;
        else if (d_on && !w_on) mode_o = amx_pkg::MODE_DRIVE;
        else if (!d_on && w_on) mode_o = amx_pkg::MODE_WEAPON;
      end
      amx_pkg::MODE_DRIVE: begin
        if (!d_on)      mode_o = amx_pkg::MODE_OFF;
        else if (w_arm) mode_o = amx_pkg::MODE_FULL;
      end
      amx_pkg::MODE_WEAPON: begin
        if (!w_on)      mode_o = amx_pkg::MODE_OFF;
        else if (d_arm) mode_o = amx_pkg::MODE_FULL;
      end
      amx_pkg::MODE_OFF: begin
        if (d_arm && w_arm) mode_o = amx_pkg::MODE_FULL;
        else if (d_arm)     mode_o = amx_pkg::MODE_DRIVE;
        else if (w_arm)     mode_o = amx_pkg::MODE_WEAPON;
      end
    endcase
  end

endmodule

// File: src/amx_wheel.sv
// Wheel level unit: scales a Q16 wheel velocity by 5/7, adds the rudder
// offset, rounds to nearest and clamps to 0..100. Depends on amx_pkg.
`timescale 1ns / 1ps

module amx_wheel (
  input  logic signed [amx_pkg::WQ_W-1:0] wq_i,
  input  logic [amx_pkg::CH_W-1:0]        rud_i,
  output logic [amx_pkg::CH_W-1:0]        level_o
);

  logic signed [amx_pkg::NUM_W-1:0] wq_x;
  logic signed [amx_pkg::NUM_W-1:0] rud_term;
  logic signed [amx_pkg::NUM_W-1:0] num;
  logic signed [amx_pkg::NUM_W-1:0] t;
  logic [9:0]                       rud7;
  logic [12:0]                      u;
  logic [23:0]                      recip;

  always_comb begin
    wq_x     = amx_pkg::NUM_W'(wq_i);
    rud7     = {rud_i, 3'b000} - {3'b000, rud_i};
    // rudder times 7 * 65536, the common denominator of the mix
    rud_term = $signed({3'b000, rud7, 16'h0000});
    num      = (wq_x <<< 2) + wq_x + rud_term;
    t        = num + amx_pkg::ROUND_HALF;
    u        = t[amx_pkg::NUM_W-1:16];
    recip    = u[9:0] * amx_pkg::DIV7_RECIP;
    if (num <= 0) begin
      level_o = '0;
    end else if (u >= amx_pkg::SAT_U) begin
      level_o = amx_pkg::LEVEL_MAX;
    end else begin
      level_o = recip[22:16];
    end
  end

endmodule

// File: src/arming_interlock_with_drive_mixer_top.sv
// Top level of the arming interlock with three-wheel omni drive mixer.
// Depends on amx_pkg, amx_arm and amx_wheel.
//
//   Channel  Direction  Ports                            Payload
//   in_      slave      in_tvalid in_tready in_tdata     one tick, 72 bits
//   out_     master     out_tvalid out_tready out_tdata  one result, 32 bits
//   cfg_     write      cfg_we cfg_index cfg_data        five 7-bit registers
//
// A tick is accepted only in the idle state, and the next one only after the
// result of the last has loaded: one shared 18 x 8 signed multiplier forms
// x*x, y*y, deadzone squared and sqrt(3)/2 * y in four steps, and one shared
// wheel level unit then evaluates the three wheels in three more steps.
// Reset (rst_n low, synchronous) disarms the block, loads the register
// defaults and empties the output stage. A stalled result holds the output
// stage; the next transaction is taken while it waits, and the finished
// result of that one waits in turn until the output stage is free.
`timescale 1ns / 1ps

module arming_interlock_with_drive_mixer_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata from bit 0 up: weapon_arm_switch, weapon_throttle,
  // weapon_elevation, weapon_rudder, weapon_aileron, drive_arm_switch,
  // drive_throttle, drive_elevation, drive_rudder, drive_aileron (7 bits
  // each), weapon_link_lost, drive_link_lost (1 bit each).
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [amx_pkg::IN_TDATA_W-1:0]      in_tdata,
  // out_tdata from bit 0 up: arm_mode (2), drive_enable (1),
  // weapon_enable (1), wheel_a, wheel_b, wheel_c, weapon_drive_level (7 each).
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [amx_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                cfg_we,
  input  logic [amx_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [amx_pkg::CH_W-1:0]            cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_DZ,
    ST_SY,
    ST_WA,
    ST_WB,
    ST_WC,
    ST_DONE
  } state_t;

  state_t                           state_r;
  amx_pkg::mode_t                   mode_r;
  amx_pkg::mode_t                   mode_nxt;
  amx_pkg::cfg_t                    cfg_r;
  amx_pkg::chan_t                   weapon_ch;
  amx_pkg::chan_t                   drive_ch;

  logic signed [7:0]                x_r;
  logic signed [7:0]                y_r;
  logic signed [7:0]                x_nxt;
  logic signed [7:0]                y_nxt;
  logic [amx_pkg::CH_W-1:0]         rud_r;
  logic [amx_pkg::CH_W-1:0]         wlevel_r;
  logic [amx_pkg::CH_W-1:0]         wlevel_nxt;
  logic [15:0]                      acc_r;
  logic                             outside_r;
  logic signed [23:0]               sy_r;
  logic [amx_pkg::CH_W-1:0]         wa_r;
  logic [amx_pkg::CH_W-1:0]         wb_r;
  logic [amx_pkg::CH_W-1:0]         wc_r;
  logic                             out_valid_r;
  logic [amx_pkg::OUT_TDATA_W-1:0]  out_data_r;

  logic signed [17:0]               mul_a;
  logic signed [7:0]                mul_b;
  logic signed [25:0]               prod;
  logic signed [amx_pkg::WQ_W-1:0]  wq;
  logic signed [amx_pkg::WQ_W-1:0]  x_wide;
  logic signed [amx_pkg::WQ_W-1:0]  sy_wide;
  logic [amx_pkg::CH_W-1:0]         level;
  logic                             drive_en;
  logic                             weapon_en;
  logic                             in_hs;
  logic                             out_load;

  // Unpack the incoming tick.
  always_comb begin
    weapon_ch.sw   = in_tdata[6:0];
    weapon_ch.thr  = in_tdata[13:7];
    weapon_ch.el   = in_tdata[20:14];
    weapon_ch.ru   = in_tdata[27:21];
    weapon_ch.ai   = in_tdata[34:28];
    drive_ch.sw    = in_tdata[41:35];
    drive_ch.thr   = in_tdata[48:42];
    drive_ch.el    = in_tdata[55:49];
    drive_ch.ru    = in_tdata[62:56];
    drive_ch.ai    = in_tdata[69:63];
    weapon_ch.lost = in_tdata[70];
    drive_ch.lost  = in_tdata[71];
  end

  amx_arm u_arm (
    .mode_i   (mode_r),
    .weapon_i (weapon_ch),
    .drive_i  (drive_ch),
    .cfg_i    (cfg_r),
    .mode_o   (mode_nxt)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign in_hs     = in_tvalid && in_tready;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  // Stick offsets from centre and the gated weapon level of the new tick.
  always_comb begin
    x_nxt = $signed({1'b0, drive_ch.ai}) - $signed({1'b0, amx_pkg::CH_CENTRE});
    y_nxt = $signed({1'b0, drive_ch.el}) - $signed({1'b0, amx_pkg::CH_CENTRE});
    if (!(mode_nxt == amx_pkg::MODE_WEAPON || mode_nxt == amx_pkg::MODE_FULL)) begin
      wlevel_nxt = '0;
    end else if (weapon_ch.thr > amx_pkg::LEVEL_MAX) begin
      wlevel_nxt = amx_pkg::LEVEL_MAX;
    end else begin
      wlevel_nxt = weapon_ch.thr;
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = 18'(x_r);
    mul_b = x_r;
    unique case (state_r)
      ST_SQY: begin
        mul_a = 18'(y_r);
        mul_b = y_r;
      end
      ST_DZ: begin
        mul_a = {11'b0, cfg_r.deadzone};
        mul_b = {1'b0, cfg_r.deadzone};
      end
      ST_SY: begin
        mul_a = amx_pkg::SQRT3_HALF_Q16;
        mul_b = y_r;
      end
      ST_IDLE, ST_SQX, ST_WA, ST_WB, ST_WC, ST_DONE: begin
        mul_a = 18'(x_r);
        mul_b = x_r;
      end
      default: begin
        mul_a = 18'(x_r);
        mul_b = x_r;
      end
    endcase
    prod = mul_a * mul_b;
  end

  // Wheel velocity in Q16 for the wheel under evaluation; zero inside
  // the deadzone.
  always_comb begin
    x_wide  = amx_pkg::WQ_W'(x_r);
    sy_wide = amx_pkg::WQ_W'(sy_r);
    wq      = '0;
    if (outside_r) begin
      unique case (state_r)
        ST_WA:   wq = -(x_wide <<< 16);
        ST_WB:   wq = (x_wide <<< 15) - sy_wide;
        ST_WC:   wq = (x_wide <<< 15) + sy_wide;
        default: wq = '0;
      endcase
    end
  end

  amx_wheel u_wheel (
    .wq_i    (wq),
    .rud_i   (rud_r),
    .level_o (level)
  );

  assign drive_en  = (mode_r == amx_pkg::MODE_DRIVE) || (mode_r == amx_pkg::MODE_FULL);
  assign weapon_en = (mode_r == amx_pkg::MODE_WEAPON) || (mode_r == amx_pkg::MODE_FULL);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.switch_thr <= amx_pkg::RST_SWITCH_THR;
      cfg_r.centre_lo  <= amx_pkg::RST_CENTRE_LO;
      cfg_r.centre_hi  <= amx_pkg::RST_CENTRE_HI;
      cfg_r.thr_max    <= amx_pkg::RST_THR_MAX;
      cfg_r.deadzone   <= amx_pkg::RST_DEADZONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        amx_pkg::CFG_SWITCH_THR: cfg_r.switch_thr <= cfg_data;
        amx_pkg::CFG_CENTRE_LO:  cfg_r.centre_lo  <= cfg_data;
        amx_pkg::CFG_CENTRE_HI:  cfg_r.centre_hi  <= cfg_data;
        amx_pkg::CFG_THR_MAX:    cfg_r.thr_max    <= cfg_data;
        amx_pkg::CFG_DEADZONE:   cfg_r.deadzone   <= cfg_data;
        default: begin
          // Indexes beyond the register list are ignored.
        end
      endcase
    end
  end

  // Sequencer with the datapath registers and the output stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= amx_pkg::MODE_OFF;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_hs) begin
            mode_r   <= mode_nxt;
            x_r      <= x_nxt;
            y_r      <= y_nxt;
            rud_r    <= drive_ch.ru;
            wlevel_r <= wlevel_nxt;
            state_r  <= ST_SQX;
          end
        end
        ST_SQX: begin
          acc_r   <= prod[15:0];
          state_r <= ST_SQY;
        end
        ST_SQY: begin
          acc_r   <= acc_r + prod[15:0];
          state_r <= ST_DZ;
        end
        ST_DZ: begin
          outside_r <= acc_r > prod[15:0];
          state_r   <= ST_SY;
        end
        ST_SY: begin
          sy_r    <= prod[23:0];
          state_r <= ST_WA;
        end
        ST_WA: begin
          wa_r    <= level;
          state_r <= ST_WB;
        end
        ST_WB: begin
          wb_r    <= level;
          state_r <= ST_WC;
        end
        ST_WC: begin
          wc_r    <= level;
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) begin
            out_data_r[1:0]   <= mode_r;
            out_data_r[2]     <= drive_en;
            out_data_r[3]     <= weapon_en;
            out_data_r[10:4]  <= drive_en ? wa_r : amx_pkg::WHEEL_STOP;
            out_data_r[17:11] <= drive_en ? wb_r : amx_pkg::WHEEL_STOP;
            out_data_r[24:18] <= drive_en ? wc_r : amx_pkg::WHEEL_STOP;
            out_data_r[31:25] <= wlevel_r;
            state_r           <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: src/amx_checker.sv
// Port-level checker of the arming interlock top level, bound to it below.
// Depends on amx_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module amx_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [amx_pkg::OUT_TDATA_W-1:0] out_tdata
);

  `AMX_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed or dropped while stalled")
  `AMX_ASSERT_IMP(a_drive_en, clk, rst_n, out_tvalid, out_tdata[2] == out_tdata[0], "drive enable does not match mode")
  `AMX_ASSERT_IMP(a_weapon_en, clk, rst_n, out_tvalid, out_tdata[3] == out_tdata[1], "weapon enable does not match mode")
  `AMX_ASSERT_IMP(a_wheel_stop, clk, rst_n, out_tvalid && !out_tdata[2], out_tdata[10:4] == amx_pkg::WHEEL_STOP && out_tdata[17:11] == amx_pkg::WHEEL_STOP && out_tdata[24:18] == amx_pkg::WHEEL_STOP, "wheels not stopped with drive disabled")
  `AMX_ASSERT_IMP(a_weapon_off, clk, rst_n, out_tvalid && !out_tdata[3], out_tdata[31:25] == '0, "weapon level nonzero with weapon disabled")

endmodule

bind arming_interlock_with_drive_mixer_top amx_checker u_amx_checker (.*);
